### sv/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg: shared types and constants for the polygon point-inclusion block
// Field widths, register indexes, action codes and edge decision codes.
// ----------------------------------------------------------------------------
package spi_pkg;

    // fixed field widths
    localparam int VI_W       = 11;   // vertex_index
    localparam int VC_W       = 12;   // vertex_count register
    localparam int TOL_W      = 10;   // crossing_tolerance register
    localparam int CNT_W      = 12;   // crossing_count result
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(10);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_TOL    = CFG_IDX_W'(1);

    // input actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // per-edge decision after classification
    typedef enum logic [1:0] {
        DEC_SKIP = 2'd0,
        DEC_HIT  = 2'd1,
        DEC_CMP  = 2'd2
    } t_dec;

endpackage

### sv/scan_polygon_point_inclusion.sv
// ----------------------------------------------------------------------------
// scan_polygon_point_inclusion: crossing-number point-in-polygon test
// Vertex store plus a pipelined edge evaluator walked by a small sequencer.
// ----------------------------------------------------------------------------
// A load transaction (action 0) writes one vertex into the on-chip vertex
// store; the block is ready again on the next cycle and returns no result.
// For a query transaction (action 1), let n be vertex_count clamped to
// MAX_VERTICES: the sequencer reads the store through its single read port
// once per cycle, vertices 0..n-1 and vertex 0 again to close the polygon
// (n + 1 reads), and each read after the first feeds one edge into the
// shared edge unit. The edge unit classifies the edge, forms the two cross
// products on successive stages and compares them, so the walk over the
// memory port sets the query time. An empty polygon skips the walk and goes
// straight to the finish state. A finished result sits in an output
// register, so a new transaction can be taken while it waits on stall.
// Configuration writes are always accepted but must only be issued while
// no query is in flight. The vertex store has no reset; every vertex a
// query touches must have been loaded first.
// ----------------------------------------------------------------------------
module scan_polygon_point_inclusion
    import spi_pkg::*;
#(
    parameter int MAX_VERTICES = 2048,
    parameter int COORD_BITS   = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input items
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_action,
    input  logic [VI_W-1:0]              i_vertex_index,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    // results
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_inside_res,
    output logic [CNT_W-1:0]             o_crossing_count,
    // configuration writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int C   = COORD_BITS;
    localparam int AW  = $clog2(MAX_VERTICES);        // store address
    localparam int NW  = $clog2(MAX_VERTICES + 1);    // holds 0..MAX_VERTICES
    localparam int LW  = (VC_W > NW) ? VC_W : NW;     // clamp compare width
    localparam int EW  = ((VI_W > AW) ? VI_W : AW) + 1;
    localparam int DW  = C + 1;                       // coordinate differences
    localparam int RW  = C + 2;                       // px + tol - p1x
    localparam int PLW = 2 * DW;                      // lhs product
    localparam int PRW = RW + DW;                     // rhs product

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    // ---------------------------------------------------------------- config
    logic [VC_W-1:0]  r_vertex_count;
    logic [TOL_W-1:0] r_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_tol          <= TOL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data[VC_W-1:0];
                CFG_CROSS_TOL:    r_tol          <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- input side
    logic r_out_valid;
    logic [1:0] r_state, n_state;

    logic in_acc, load_acc, query_acc;
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign load_acc   = in_acc && (i_action == ACT_LOAD);
    assign query_acc  = in_acc && (i_action == ACT_QUERY);

    // vertex count clamped to the store depth
    logic [LW-1:0] vc_ext, n_full;
    logic [NW-1:0] n_clamped;
    assign vc_ext    = LW'(r_vertex_count);
    assign n_full    = (vc_ext > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : vc_ext;
    assign n_clamped = n_full[NW-1:0];

    // load slot; indexes beyond the store are dropped
    logic [EW-1:0] wr_idx_ext;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    assign wr_idx_ext = EW'(i_vertex_index);
    assign wr_en      = load_acc && (wr_idx_ext < EW'(MAX_VERTICES));
    assign wr_addr    = wr_idx_ext[AW-1:0];

    // query point, latched for the whole walk
    logic signed [C-1:0] r_qx, r_qy;
    logic [NW-1:0]       r_n;

    always_ff @(posedge i_clk) begin
        if (query_acc) begin
            r_qx <= i_coord_x;
            r_qy <= i_coord_y;
            r_n  <= n_clamped;
        end
    end

    // ------------------------------------------------------------ sequencer
    logic [NW-1:0] r_rd_cnt, n_rd_cnt;
    logic          rd_en, fin_load, out_free, pipe_busy;
    logic          r_rd_vld, r_s2_vld, r_s3_vld, r_s4_vld;

    assign pipe_busy = r_rd_vld || r_s2_vld || r_s3_vld || r_s4_vld;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_rd_cnt = r_rd_cnt;
        rd_en    = 1'b0;
        fin_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (query_acc) begin
                    n_rd_cnt = '0;
                    n_state  = (n_clamped == '0) ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN: begin
                rd_en = 1'b1;
                if (r_rd_cnt == r_n) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    fin_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_cnt <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_cnt <= n_rd_cnt;
        end
    end

    // --------------------------------------------------------- vertex store
    // {x, y} per entry; last read wraps back to vertex 0 to close the polygon
    logic [2*C-1:0] r_vtx_mem [MAX_VERTICES];
    logic [2*C-1:0] r_rd_data, r_prev;
    logic [AW-1:0]  rd_addr;
    logic           r_rd_first;

    assign rd_addr = (r_rd_cnt == r_n) ? '0 : r_rd_cnt[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_vtx_mem[wr_addr] <= {i_coord_x, i_coord_y};
        end
        if (rd_en) begin
            r_rd_data <= r_vtx_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
        end
        r_rd_first <= rd_en && (r_rd_cnt == '0);
        if (r_rd_vld) begin
            r_prev <= r_rd_data;
        end
    end

    // ------------------------------------------------ stage 2: classify edge
    logic signed [C-1:0]  p1x, p1y, p2x, p2y;
    logic signed [DW-1:0] d, a_pos, a_neg, b, m;
    logic signed [RW-1:0] r;
    logic                 skip, upper, vert;
    t_dec                 dec;

    assign p1x = r_prev[2*C-1:C];
    assign p1y = r_prev[C-1:0];
    assign p2x = r_rd_data[2*C-1:C];
    assign p2y = r_rd_data[C-1:0];

    assign d     = {p2y[C-1], p2y} - {p1y[C-1], p1y};
    assign a_pos = {r_qy[C-1], r_qy} - {p1y[C-1], p1y};
    assign a_neg = {p1y[C-1], p1y} - {r_qy[C-1], r_qy};
    assign b     = {p2x[C-1], p2x} - {p1x[C-1], p1x};
    assign m     = d[DW-1] ? -d : d;
    assign r     = {{2{r_qx[C-1]}}, r_qx} + {{(RW-TOL_W){1'b0}}, r_tol}
                 - {{2{p1x[C-1]}}, p1x};

    // skip: wholly left, horizontal, or point outside the edge's y span
    assign skip  = ((p1x < r_qx) && (p2x < r_qx)) || (p1y == p2y)
                 || ((r_qy < p1y) && (r_qy < p2y))
                 || ((r_qy > p1y) && (r_qy > p2y));
    assign upper = (p2y == r_qy) && (r_qx < p2x);
    assign vert  = (p1x == p2x);

    always_comb begin
        if (skip) begin
            dec = DEC_SKIP;
        end else if (upper) begin
            dec = DEC_HIT;
        end else if (vert) begin
            dec = (r_qx < p1x) ? DEC_HIT : DEC_SKIP;
        end else begin
            dec = DEC_CMP;
        end
    end

    // intersection test: sgn(d)*(py-p1y)*(p2x-p1x) > (px+tol-p1x)*|d|
    t_dec                  r_s2_dec, r_s3_dec, r_s4_dec;
    logic signed [DW-1:0]  r_s2_a, r_s2_b, r_s2_m, r_s3_m;
    logic signed [RW-1:0]  r_s2_r, r_s3_r;
    logic signed [PLW-1:0] r_s3_lhs, r_s4_lhs;
    logic signed [PRW-1:0] r_s4_rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_rd_vld && !r_rd_first;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
        // stage 2
        r_s2_dec <= dec;
        r_s2_a   <= d[DW-1] ? a_neg : a_pos;
        r_s2_b   <= b;
        r_s2_m   <= m;
        r_s2_r   <= r;
        // stage 3: left cross product
        r_s3_dec <= r_s2_dec;
        r_s3_lhs <= r_s2_a * r_s2_b;
        r_s3_r   <= r_s2_r;
        r_s3_m   <= r_s2_m;
        // stage 4: right cross product
        r_s4_dec <= r_s3_dec;
        r_s4_lhs <= r_s3_lhs;
        r_s4_rhs <= r_s3_r * r_s3_m;
    end

    // ------------------------------------------------------ count crossings
    logic signed [PRW-1:0] lhs_ext;
    logic                  crossed;
    logic [CNT_W-1:0]      r_count;
    logic                  r_par;

    assign lhs_ext = {r_s4_lhs[PLW-1], r_s4_lhs};

    always_comb begin
        case (r_s4_dec)
            DEC_HIT: crossed = 1'b1;
            DEC_CMP: crossed = (lhs_ext > r_s4_rhs);
            default: crossed = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (query_acc) begin
            r_count <= '0;
            r_par   <= 1'b0;
        end else if (r_s4_vld && crossed) begin
            r_par <= !r_par;
            if (r_count != CNT_MAX) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // -------------------------------------------------------- result output
    logic             r_out_inside;
    logic [CNT_W-1:0] r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (fin_load) begin
            r_out_inside <= r_par;
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_inside_res     = r_out_inside;
    assign o_crossing_count = r_out_count;

endmodule

### sv/spi_checker.sv
// ----------------------------------------------------------------------------
// spi_checker: port-level checks for the point-inclusion block
// Watches handshakes and results over time; attached by bind.
// ----------------------------------------------------------------------------
module spi_checker
    import spi_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             i_action,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic             o_inside_res,
    input logic [CNT_W-1:0] o_crossing_count
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_inside_res) && $stable(o_crossing_count))
        else $error("result changed while stalled");

    // unsaturated count and parity agree
    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_crossing_count != CNT_MAX) |->
            (o_inside_res == o_crossing_count[0]))
        else $error("inside flag disagrees with crossing count");

    // a load transaction never blocks the next one
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_action == ACT_LOAD) |=> !o_in_stall)
        else $error("busy after a load");

    // a query transaction makes the block busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_action == ACT_QUERY) |=> o_in_stall)
        else $error("not busy after a query");

    // a new result only shows up at the end of a busy walk
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a preceding query");

endmodule

bind scan_polygon_point_inclusion spi_checker u_spi_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_action         (i_action),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_inside_res     (o_inside_res),
    .o_crossing_count (o_crossing_count)
);
